// ----- hw/rtl/kbms_pkg.sv -----
// kbms_pkg: shared constants, types and hash helpers for the bottom-s sketch block.
// No dependencies.
package kbms_pkg;

	localparam int WINDOW_LENGTH_DEF   = 4;
	localparam int MAX_SKETCH_SIZE_DEF = 8;
	localparam logic [31:0] SEED_RESET = 32'd42;
	localparam logic [3:0]  SIZE_RESET = 4'd5;

	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] F1 = 32'h85ebca6b;
	localparam logic [31:0] F2 = 32'hc2b2ae35;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;

	// register indexes
	localparam logic [0:0] REG_SEED = 1'b0;
	localparam logic [0:0] REG_SIZE = 1'b1;

	// one classified window handed from front to back
	typedef struct packed {
		logic        has_window;
		logic        eos;
		logic [31:0] hash;
		logic [31:0] pos;
	} kbms_job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_INSERT,
		BK_EMIT
	} kbms_bk_state_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
		rotl32 = (x << r) | (x >> (32 - r));
	endfunction

endpackage

// ----- hw/rtl/kmer_bottom_s_minhash_sketch.sv -----
// kmer_bottom_s_minhash_sketch: bottom-s MinHash sketch, top level.
// One byte transfer is taken at a time: busy stays high until the hash sequencer
// (one multiply per cycle), then queue, dispatch and insert are done with it.
// End of sequence: m results (m >= 1) one per cycle; busy stays high while they are
// emitted. Results cannot be stalled.
// Reset (arst_n low) clears window, counters and sketch; seed 42, size 5.
module kmer_bottom_s_minhash_sketch import kbms_pkg::*; #(
	parameter int WINDOW_LENGTH   = WINDOW_LENGTH_DEF,
	parameter int MAX_SKETCH_SIZE = MAX_SKETCH_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  symbol,
	input  logic        end_of_sequence,
	output logic        result_valid,
	output logic [31:0] sequence_number,
	output logic [31:0] min_hash,
	output logic [31:0] first_position,
	output logic [31:0] occurrences,
	output logic        entry_valid,
	output logic        last_entry,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [31:0] seed_q;
	logic [3:0]  size_q;
	logic        accept, fjob_v, q_ne, q_full, pop, bk_idle, pend_q;
	kbms_job_t   fjob, qhead;

	// config registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET; size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_SEED) seed_q <= pwdata;
			else if (paddr[2] == REG_SIZE) size_q <= pwdata[3:0];
		end
	end
	assign prdata = (paddr[2] == REG_SEED) ? seed_q : {28'd0, size_q};

	// one item in flight at a time
	assign accept = start && !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else if (accept) pend_q <= 1'b1;
		else if (pop) pend_q <= 1'b0;
	end
	assign busy = pend_q || q_ne || !bk_idle;

	kbms_front #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_front (
		.clk, .arst_n, .in_valid(accept), .symbol, .end_of_sequence,
		.seed(seed_q), .job_valid(fjob_v), .job(fjob)
	);

	kbms_queue u_queue (
		.clk, .arst_n, .push(fjob_v && !q_full), .push_data(fjob), .pop,
		.not_empty(q_ne), .full(q_full), .head(qhead)
	);

	kbms_back #(.MAX_SKETCH_SIZE(MAX_SKETCH_SIZE)) u_back (
		.clk, .arst_n, .job_valid(q_ne), .job(qhead), .job_pop(pop),
		.sketch_size(size_q), .idle(bk_idle), .result_valid,
		.sequence_number, .min_hash, .first_position, .occurrences,
		.entry_valid, .last_entry
	);

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("accepted item did not raise busy");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_ne) else $error("queue popped while empty");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(fjob_v && q_full)) else $error("queue overflow");
endmodule

// ----- hw/rtl/kbms_front.sv -----
// kbms_front: window shift line, position count and phase-sequenced MurmurHash3 of each window.
// Depends on kbms_pkg.
module kbms_front import kbms_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      symbol,
	input  logic            end_of_sequence,
	input  logic [31:0]     seed,
	output logic            job_valid,
	output kbms_job_t       job
);
	localparam int NBLK = WINDOW_LENGTH / 4;
	localparam int REST = WINDOW_LENGTH % 4;
	localparam int NW   = (REST != 0) ? NBLK + 1 : NBLK;
	localparam int SW   = (NW > 1) ? $clog2(NW) : 1;

	logic [7:0]  win_q [WINDOW_LENGTH];
	logic [31:0] seen_q;
	logic [7:0]  nwin  [WINDOW_LENGTH];
	logic [31:0] nseen;

	// sequencer for the block loop
	logic        busy_q, has_q, eos_q;
	logic [SW-1:0] blk_q;
	logic [1:0]  ph_q;
	logic [31:0] h_q, k_q, pos_q;
	logic [7:0]  hw_q [WINDOW_LENGTH];
	logic [31:0] word;

	always_comb begin
		for (int i = 0; i < WINDOW_LENGTH - 1; i++) nwin[i] = win_q[i + 1];
		nwin[WINDOW_LENGTH - 1] = symbol;
		nseen = (seen_q == 32'hFFFFFFFF) ? seen_q : seen_q + 32'd1;
	end

	// word of the current block, little endian; tail zero padded
	always_comb begin
		word = '0;
		for (int j = 0; j < WINDOW_LENGTH; j++)
			if (32'(j / 4) == 32'(blk_q))
				word[(j % 4)*8 +: 8] = hw_q[j];
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LENGTH; i++) win_q[i] <= '0;
			seen_q <= '0;
		end else if (in_valid) begin
			if (end_of_sequence) begin
				for (int i = 0; i < WINDOW_LENGTH; i++) win_q[i] <= '0;
				seen_q <= '0;
			end else begin
				win_q  <= nwin;
				seen_q <= nseen;
			end
		end
	end

	// hash sequencer: per block mul C1, rot+mul C2, xor into h, mix (full blocks), then finalize
	logic fin_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; job_valid <= 1'b0; fin_q <= 1'b0;
			blk_q <= '0; ph_q <= '0;
		end else begin
			job_valid <= 1'b0;
			if (in_valid) begin
				busy_q <= 1'b1; fin_q <= (NW == 0);
				blk_q <= '0; ph_q <= '0;
				hw_q <= nwin; h_q <= seed;
				has_q <= (nseen >= 32'(WINDOW_LENGTH));
				eos_q <= end_of_sequence;
				pos_q <= nseen - 32'(WINDOW_LENGTH);
			end else if (busy_q && !fin_q) begin
				ph_q <= ph_q + 2'd1;
				case (ph_q)
					2'd0: k_q <= word * C1;
					2'd1: k_q <= rotl32(k_q, 15) * C2;
					2'd2: begin
						if (32'(blk_q) < NBLK)
							h_q <= rotl32(h_q ^ k_q, 13);
						else
							h_q <= h_q ^ k_q;
					end
					default: begin
						if (32'(blk_q) < NBLK) h_q <= h_q * 32'd5 + MIX_ADD;
						if (32'(blk_q) == NW - 1) fin_q <= 1'b1;
						else blk_q <= blk_q + 1'b1;
					end
				endcase
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				case (ph_q)
					2'd0: begin
						k_q <= h_q ^ 32'(WINDOW_LENGTH);
						h_q <= (h_q ^ 32'(WINDOW_LENGTH)) ^ ((h_q ^ 32'(WINDOW_LENGTH)) >> 16);
					end
					2'd1: h_q <= h_q * F1;
					2'd2: begin
						k_q <= (h_q ^ (h_q >> 13));
						h_q <= (h_q ^ (h_q >> 13)) * F2;
					end
					default: begin
						h_q <= h_q ^ (h_q >> 16);
						busy_q <= 1'b0;
						job_valid <= 1'b1;
					end
				endcase
			end
		end
	end

	assign job.has_window = has_q;
	assign job.eos  = eos_q;
	assign job.hash = h_q;
	assign job.pos  = pos_q;
endmodule

// ----- hw/rtl/kbms_queue.sv -----
// kbms_queue: two-entry queue between hash front and sketch back.
// Depends on kbms_pkg.
module kbms_queue import kbms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  kbms_job_t push_data,
	input  logic      pop,
	output logic      not_empty,
	output logic      full,
	output kbms_job_t head
);
	kbms_job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign not_empty = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign head      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- hw/rtl/kbms_back.sv -----
// kbms_back: sorted sketch table, insertion of window hashes and emission at sequence end.
// Depends on kbms_pkg.
module kbms_back import kbms_pkg::*; #(
	parameter int MAX_SKETCH_SIZE = MAX_SKETCH_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  kbms_job_t   job,
	output logic        job_pop,
	input  logic [3:0]  sketch_size,
	output logic        idle,
	output logic        result_valid,
	output logic [31:0] sequence_number,
	output logic [31:0] min_hash,
	output logic [31:0] first_position,
	output logic [31:0] occurrences,
	output logic        entry_valid,
	output logic        last_entry
);
	localparam int M  = MAX_SKETCH_SIZE;
	localparam int NB = $clog2(M + 1);
	localparam int IB = (M > 1) ? $clog2(M) : 1;

	logic [31:0] hash_q [M];
	logic [31:0] posn_q [M];
	logic [31:0] cnt_q  [M];
	logic [NB-1:0] used_q;
	logic [31:0] seq_q;
	kbms_bk_state_t st_q, st_d;
	logic [IB-1:0] emi_q;
	logic [NB-1:0] em_n_q;

	// effective size
	logic [NB-1:0] size_eff;
	always_comb begin
		if (sketch_size == 4'd0) size_eff = NB'(1);
		else if (32'(sketch_size) > M) size_eff = NB'(M);
		else size_eff = NB'(sketch_size);
	end

	// parallel compare against all kept entries
	logic [M-1:0] hit, less;
	logic         any_hit, do_ins;
	logic [NB-1:0] ins_at, nn;
	always_comb begin
		ins_at = used_q;
		for (int i = M - 1; i >= 0; i--) begin
			hit[i]  = (NB'(i) < used_q) && (hash_q[i] == job.hash);
			less[i] = (NB'(i) < used_q) && (hash_q[i] < job.hash);
			if ((NB'(i) < used_q) && !less[i]) ins_at = NB'(i);
		end
		any_hit = |hit;
		do_ins  = !any_hit && ((used_q < size_eff) ||
			(used_q != '0 && !less[IB'(used_q - NB'(1))] ));
		nn = (used_q + NB'(1) > size_eff) ? size_eff : used_q + NB'(1);
	end

	// control
	always_comb begin
		st_d = st_q;
		job_pop = 1'b0;
		case (st_q)
			BK_IDLE:   if (job_valid) st_d = BK_INSERT;
			BK_INSERT: begin
				job_pop = 1'b1;
				st_d = job.eos ? BK_EMIT : BK_IDLE;
			end
			BK_EMIT:   if (32'(emi_q) + 1 >= 32'(em_n_q)) st_d = BK_IDLE;
			default:   st_d = BK_IDLE;
		endcase
	end
	assign idle = (st_q == BK_IDLE) && !job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else         st_q <= st_d;
	end

	// table update, emission count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0; seq_q <= '0; emi_q <= '0; em_n_q <= '0;
		end else begin
			if (st_q == BK_INSERT) begin
				if (job.has_window && do_ins) used_q <= nn;
				if (job.eos)
					emi_q <= '0;
			end else if (st_q == BK_EMIT) begin
				emi_q <= emi_q + 1'b1;
				if (32'(emi_q) + 1 >= 32'(em_n_q)) begin
					used_q <= '0;
					seq_q  <= seq_q + 32'd1;
				end
			end
			// latch emission length once insertion settled
			if (st_q == BK_INSERT && job.eos)
				em_n_q <= '1;
			else if (st_q == BK_EMIT && emi_q == '0)
				em_n_q <= (used_q > size_eff) ? size_eff : used_q;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_INSERT && job.has_window) begin
			if (any_hit) begin
				for (int i = 0; i < M; i++)
					if (hit[i] && cnt_q[i] != 32'hFFFFFFFF) cnt_q[i] <= cnt_q[i] + 32'd1;
			end else if (do_ins) begin
				for (int i = 0; i < M; i++) begin
					if (NB'(i) == ins_at) begin
						hash_q[i] <= job.hash; posn_q[i] <= job.pos; cnt_q[i] <= 32'd1;
					end else if (NB'(i) > ins_at && i > 0) begin
						hash_q[i] <= hash_q[(i + M - 1) % M];
						posn_q[i] <= posn_q[(i + M - 1) % M];
						cnt_q[i]  <= cnt_q[(i + M - 1) % M];
					end
				end
			end
		end
	end

	// emission output register
	logic [NB-1:0] m_now;
	assign m_now = (used_q > size_eff) ? size_eff : used_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (st_q == BK_EMIT && (emi_q == '0 || 32'(emi_q) < 32'(em_n_q))) begin
				result_valid <= 1'b1;
				sequence_number <= seq_q;
				if (m_now == '0) begin
					min_hash <= '0; first_position <= '0; occurrences <= '0;
					entry_valid <= 1'b0; last_entry <= 1'b1;
				end else begin
					min_hash <= hash_q[emi_q];
					first_position <= posn_q[emi_q];
					occurrences <= cnt_q[emi_q];
					entry_valid <= 1'b1;
					last_entry <= (32'(emi_q) + 1 == 32'(m_now));
				end
			end
		end
	end
endmodule

// ----- sim/kbms_checker.sv -----
`timescale 1ns / 1ps
// kbms_checker: watches the byte, result and register ports of the sketch block,
// predicts each sketch entry and compares it. Depends on kbms_pkg.
module kbms_checker import kbms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [7:0]  symbol,
	input  logic        end_of_sequence,
	input  logic        result_valid,
	input  logic [31:0] sequence_number,
	input  logic [31:0] min_hash,
	input  logic [31:0] first_position,
	input  logic [31:0] occurrences,
	input  logic        entry_valid,
	input  logic        last_entry,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] hash;
		logic [31:0] pos;
		logic [31:0] count;
		logic        valid;
		logic        last;
	} sketch_entry_t;

	localparam int KMAX = MAX_SKETCH_SIZE_DEF;

	sketch_entry_t entries_due[$];

	// predictor state
	logic [31:0] seed;
	logic [3:0]  size_reg;
	logic [7:0]  win [4];
	logic [31:0] nbytes;
	logic [31:0] nseq;
	logic [31:0] kh [KMAX+1];
	logic [31:0] kp [KMAX+1];
	logic [31:0] kc [KMAX+1];
	int          in_use;

	assign pending = entries_due.size();

	function automatic logic [31:0] rot(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	// MurmurHash3 x86_32 of one 4-byte window, oldest byte lowest
	function automatic logic [31:0] murmur_window(input logic [31:0] s,
			input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3);
		logic [31:0] k;
		logic [31:0] h;
		k = {b3, b2, b1, b0};
		k = k * C1;
		k = rot(k, 15);
		k = k * C2;
		h = s ^ k;
		h = rot(h, 13);
		h = h * 32'd5 + MIX_ADD;
		h = h ^ 32'd4;
		h = h ^ (h >> 16);
		h = h * F1;
		h = h ^ (h >> 13);
		h = h * F2;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function automatic int eff_size();
		if (size_reg == 0)
			return 1;
		if (size_reg > KMAX)
			return KMAX;
		return size_reg;
	endfunction

	task automatic insert_hash(input logic [31:0] h, input logic [31:0] p);
		int n;
		int i;
		int sz;
		sz = eff_size();
		n = in_use;
		for (i = 0; i < n; i++) begin
			if (kh[i] == h) begin
				if (kc[i] != 32'hffffffff)
					kc[i]++;
				return;
			end
		end
		if (!(n < sz || (n > 0 && h < kh[n-1])))
			return;
		i = 0;
		while (i < n && kh[i] < h)
			i++;
		for (int j = n; j > i; j--) begin
			kh[j] = kh[j-1];
			kp[j] = kp[j-1];
			kc[j] = kc[j-1];
		end
		kh[i] = h;
		kp[i] = p;
		kc[i] = 1;
		n++;
		if (n > sz)
			n = sz;
		in_use = n;
	endtask

	task automatic absorb_byte(input logic [7:0] b, input logic eos);
		sketch_entry_t e;
		int m;
		win[0] = win[1];
		win[1] = win[2];
		win[2] = win[3];
		win[3] = b;
		if (nbytes != 32'hffffffff)
			nbytes++;
		if (nbytes >= 4)
			insert_hash(murmur_window(seed, win[0], win[1], win[2], win[3]), nbytes - 4);
		if (!eos)
			return;
		m = in_use;
		if (m > eff_size())
			m = eff_size();
		if (m == 0) begin
			e = '{seq: nseq, hash: 0, pos: 0, count: 0, valid: 1'b0, last: 1'b1};
			entries_due = {entries_due, e};
		end else begin
			for (int i = 0; i < m; i++) begin
				e = '{seq: nseq, hash: kh[i], pos: kp[i], count: kc[i], valid: 1'b1,
					last: (i == m - 1)};
				entries_due = {entries_due, e};
			end
		end
		nseq++;
		nbytes = 0;
		in_use = 0;
		win = '{default: 8'h00};
	endtask

	task automatic cmp(input string name, input logic [31:0] exp_v, input logic [31:0] act);
		if (exp_v !== act) begin
			$error("%s: expected %h, got %h", name, exp_v, act);
			errors++;
		end
	endtask

	initial errors = 0;

	// model update on transfers and register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed     = SEED_RESET;
			size_reg = SIZE_RESET;
			win      = '{default: 8'h00};
			nbytes   = 0;
			nseq     = 0;
			in_use   = 0;
			entries_due.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				if (paddr[2] == REG_SEED)
					seed = pwdata;
				else if (paddr[2] == REG_SIZE)
					size_reg = pwdata[3:0];
			end
			if (start && !busy)
				absorb_byte(symbol, end_of_sequence);
		end
	end

	// result comparison
	always @(posedge clk) begin
		sketch_entry_t e;
		if (arst_n && result_valid) begin
			if (entries_due.size() == 0) begin
				$error("unexpected result: seq %h hash %h", sequence_number, min_hash);
				errors++;
			end else begin
				e = entries_due.pop_front();
				cmp("sequence_number", e.seq, sequence_number);
				cmp("min_hash", e.hash, min_hash);
				cmp("first_position", e.pos, first_position);
				cmp("occurrences", e.count, occurrences);
				cmp("entry_valid", e.valid, entry_valid);
				cmp("last_entry", e.last, last_entry);
			end
		end
	end

endmodule

// ----- sim/tb_kmer_bottom_s_minhash_sketch.sv -----
`timescale 1ns / 1ps
// tb_kmer_bottom_s_minhash_sketch: drives byte sequences and register writes into
// the sketch block; checking is in kbms_checker. Depends on kbms_pkg and the RTL.
module tb_kmer_bottom_s_minhash_sketch;
	import kbms_pkg::*;

	localparam logic [2:0] ADDR_SEED = 3'd0;
	localparam logic [2:0] ADDR_SIZE = 3'd4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [7:0]  symbol = 8'h00;
	logic        end_of_sequence = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic        busy, result_valid, entry_valid, last_entry, pready;
	logic [31:0] sequence_number, min_hash, first_position, occurrences, prdata;
	int          errors, pending;
	int          bytes_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	kmer_bottom_s_minhash_sketch dut (.*);

	kbms_checker chk (.*);

	// random idle gaps, none near the end of the run
	task automatic maybe_idle();
		if (bytes_sent < 140 && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// one byte transfer; returns at the edge that accepts it
	task automatic send_byte(input logic [7:0] b, input logic eos);
		maybe_idle();
		start <= 1'b1;
		symbol <= b;
		end_of_sequence <= eos;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_seq(input string s, input logic eos_on_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eos_on_last && (i == s.len() - 1));
	endtask

	// wait until every expected entry is back and the block is quiet
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// random sequence: small alphabet for repeated windows, or any byte
	task automatic random_seq();
		int len;
		bit narrow;
		logic [7:0] b;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
		narrow = $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			b = narrow ? 8'h41 + 8'($urandom_range(0, 2)) : 8'($urandom);
			send_byte(b, i == len - 1);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, one window, short, single byte, extreme bytes, repeats
		send_seq("ACGT", 1'b1);
		send_seq("AC", 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b1);
		send_seq("AAAAAAAA", 1'b1);
		drain();

		// size 0 acts as one, all-ones seed
		reg_write(ADDR_SEED, 32'hffffffff);
		reg_write(ADDR_SIZE, 32'd0);
		send_seq("GATTACA", 1'b1);
		drain();

		// size above the maximum, then lowered mid-sequence
		reg_write(ADDR_SEED, 32'd0);
		reg_write(ADDR_SIZE, 32'd15);
		send_seq("TTGACCAG", 1'b0);
		drain();
		reg_write(ADDR_SIZE, 32'd2);
		send_seq("CATG", 1'b1);
		drain();
		reg_write(ADDR_SIZE, 32'd8);

		// random phases with fresh settings
		while (bytes_sent < 170) begin
			for (int k = 0; k < 3; k++)
				random_seq();
			drain();
			reg_write(ADDR_SEED, $urandom);
			reg_write(ADDR_SIZE, $urandom_range(0, 15));
		end

		drain();
		if (errors == 0)
			$display("tb_kmer_bottom_s_minhash_sketch: PASS");
		else
			$display("tb_kmer_bottom_s_minhash_sketch: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("tb_kmer_bottom_s_minhash_sketch: FAIL");
		$finish;
	end

endmodule
